### hw/rtl/serial_command_framer_xor_core_defines.svh
// Assertion macros used by the framer sequencer (scfx_seq).
`ifndef SERIAL_COMMAND_FRAMER_XOR_CORE_DEFINES_SVH
`define SERIAL_COMMAND_FRAMER_XOR_CORE_DEFINES_SVH

// a implies c in the same cycle
`define SCFX_ASSERT_SAME(label, a, c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error(msg);

// a implies c in the next cycle
`define SCFX_ASSERT_NEXT(label, a, c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error(msg);

`endif

### hw/rtl/scfx_pkg.sv
package scfx_pkg;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] HDR_LEN  = 4'd10;
   localparam logic [STEP_W-1:0] HDR_LAST = 4'd9;
   localparam logic [STEP_W-1:0] STEP_MAX = 4'd11;

   localparam logic [7:0] SYNC_BYTE = 8'h71;
   localparam logic [7:0] VER_BYTE  = 8'h01;
   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam logic [7:0] PAD_BYTE  = 8'h00;

   typedef struct packed {
      logic        start_req;
      logic [15:0] command_word;
      logic [15:0] endpoint;
      logic [7:0]  payload_len;
      logic        has_byte;
      logic [7:0]  payload_byte;
   } scfx_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       seq_error;
   } scfx_rsp_type;

   function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] idx,
                                           input logic [15:0] cmd,
                                           input logic [15:0] ep,
                                           input logic [7:0] len);
      logic [7:0] b;
      case (idx)
         4'd0:    b = SYNC_BYTE;
         4'd1:    b = VER_BYTE;
         4'd2:    b = cmd[15:8];
         4'd3:    b = cmd[7:0];
         4'd4:    b = FILL_BYTE;
         4'd5:    b = FILL_BYTE;
         4'd6:    b = ep[15:8];
         4'd7:    b = ep[7:0];
         4'd8:    b = PAD_BYTE;
         4'd9:    b = len;
         default: b = PAD_BYTE;
      endcase
      return b;
   endfunction

endpackage

### hw/rtl/serial_command_framer_xor_core.sv
// An accepted item is registered in the input holding register, each result in the output register.
// Throughput: one result byte per cycle unless the output register stalls; a start item yields
// 10 to 12 result bytes (one per header, payload and check byte), a payload item 1 or 2.
// An item with no result retires without waiting on the output register. The holding
// register and sequencer set the rate; a result held with rsp_tready low stalls the sequencer.
// Reset (synchronous, active high) closes any open frame and empties both stages.
module serial_command_framer_xor_core
   import scfx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command_word[15:0], endpoint[31:16], payload_len[39:32], payload_byte[47:40]
   input  logic [47:0] req_tdata,
   // start_req[0], has_byte[1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   // frame_end[0], seq_error[1]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   scfx_req_type req_item;
   scfx_rsp_type emit_item;
   scfx_rsp_type rsp_item;
   logic         emit;
   logic         out_ok;

   always_comb begin
      req_item.start_req    = req_tuser[0];
      req_item.command_word = req_tdata[15:0];
      req_item.endpoint     = req_tdata[31:16];
      req_item.payload_len  = req_tdata[39:32];
      req_item.has_byte     = req_tuser[1];
      req_item.payload_byte = req_tdata[47:40];
   end

   scfx_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_ok    (out_ok),
      .emit      (emit),
      .emit_item (emit_item)
   );

   scfx_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_item (emit_item),
      .load_ok   (out_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = rsp_item.out_byte;
   assign rsp_tuser = {rsp_item.seq_error, rsp_item.frame_end};
   assign rsp_tlast = rsp_item.run_last;

endmodule

### hw/rtl/scfx_seq.sv
`include "serial_command_framer_xor_core_defines.svh"

module scfx_seq
   import scfx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  scfx_req_type in_item,
   input  logic         out_ok,
   output logic         emit,
   output scfx_rsp_type emit_item
);

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_HDR,
      KIND_DATA,
      KIND_CHECK,
      KIND_ERR
   } kind_type;

   logic                hold_valid_ff, hold_valid_in;
   scfx_req_type        item_ff, item_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                open_ff, open_in;
   logic [7:0]          left_ff, left_in;
   logic [7:0]          xor_ff, xor_in;

   kind_type            kind;
   logic [STEP_W-1:0]   tail;
   logic [7:0]          hb;
   logic                last;
   logic                done;
   logic                accept;
   logic                check_emit;
   logic                err_emit;

   assign hb   = hdr_byte(step_ff, item_ff.command_word, item_ff.endpoint,
                          item_ff.payload_len);
   assign tail = item_ff.start_req ? step_ff - HDR_LEN : step_ff;

   always_comb begin
      kind = KIND_NONE;
      last = 1'b1;
      if (!item_ff.start_req && !item_ff.has_byte) begin
         kind = KIND_NONE;
      end else if (item_ff.start_req && step_ff < HDR_LEN) begin
         kind = KIND_HDR;
         last = (step_ff == HDR_LAST) && (item_ff.payload_len != 8'd0)
                && !item_ff.has_byte;
      end else if (tail == '0) begin
         if (item_ff.start_req) begin
            kind = (left_ff == 8'd0) ? KIND_CHECK : KIND_DATA;
         end else begin
            kind = (open_ff && left_ff != 8'd0) ? KIND_DATA : KIND_ERR;
         end
         if (kind == KIND_DATA) begin
            last = (left_ff != 8'd1);
         end
      end else begin
         kind = KIND_CHECK;
      end
   end

   always_comb begin
      emit_item = '0;
      emit_item.run_last = last;
      case (kind)
         KIND_HDR:   emit_item.out_byte = hb;
         KIND_DATA:  emit_item.out_byte = item_ff.payload_byte;
         KIND_CHECK: begin
            emit_item.out_byte  = xor_ff;
            emit_item.frame_end = 1'b1;
         end
         KIND_ERR:   emit_item.seq_error = 1'b1;
         default:    emit_item = '0;
      endcase
   end

   assign emit     = hold_valid_ff && (kind != KIND_NONE) && out_ok;
   assign done     = hold_valid_ff && ((kind == KIND_NONE) || (emit && last));
   assign in_ready = !hold_valid_ff || done;
   assign accept   = in_valid && in_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      item_in       = item_ff;
      step_in       = step_ff;
      open_in       = open_ff;
      left_in       = left_ff;
      xor_in        = xor_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         item_in       = in_item;
         step_in       = '0;
      end else if (done) begin
         hold_valid_in = 1'b0;
         step_in       = '0;
      end else if (emit) begin
         step_in = step_ff + 4'd1;
      end
      if (emit) begin
         case (kind)
            KIND_HDR: begin
               xor_in = ((step_ff == '0) ? 8'd0 : xor_ff) ^ hb;
               if (step_ff == HDR_LAST) begin
                  left_in = item_ff.payload_len;
                  open_in = (item_ff.payload_len != 8'd0);
               end
            end
            KIND_DATA: begin
               xor_in  = xor_ff ^ item_ff.payload_byte;
               left_in = left_ff - 8'd1;
            end
            KIND_CHECK: begin
               open_in = 1'b0;
               xor_in  = 8'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         step_ff       <= '0;
         open_ff       <= 1'b0;
         left_ff       <= 8'd0;
         xor_ff        <= 8'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         step_ff       <= step_in;
         open_ff       <= open_in;
         left_ff       <= left_in;
         xor_ff        <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign check_emit = emit && (kind == KIND_CHECK);
   assign err_emit   = emit && (kind == KIND_ERR);

   `SCFX_ASSERT_SAME(a_emit_held, emit, hold_valid_ff, "emit without held item")
   `SCFX_ASSERT_SAME(a_step_range, hold_valid_ff, step_ff <= STEP_MAX, "step overrun")
   `SCFX_ASSERT_NEXT(a_check_clears, check_emit, !open_ff && xor_ff == 8'd0, "frame left open")
   `SCFX_ASSERT_SAME(a_err_alone, err_emit, step_ff == '0 && last, "error result not single")

endmodule

### hw/rtl/scfx_out_reg.sv
module scfx_out_reg
   import scfx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  scfx_rsp_type load_item,
   output logic         load_ok,
   output logic         out_valid,
   input  logic         out_ready,
   output scfx_rsp_type out_item
);

   logic         valid_ff, valid_in;
   scfx_rsp_type data_ff, data_in;

   assign load_ok = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_item;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = data_ff;

endmodule
